// ----- rtl/pcpp_pkg.sv -----
package pcpp_pkg;

    localparam int IMAGE_WIDTH  = 1280;
    localparam int IMAGE_HEIGHT = 1024;

    localparam int PIX_W  = 12;
    localparam int COORD_W = 34;
    localparam int NUM_W  = 52;
    localparam int REM_W  = 50;
    localparam int DEN_W  = 48;
    localparam int NCELLS = PIX_W;

    localparam logic [2:0] REG_ROW_X    = 3'd0;
    localparam logic [2:0] REG_ROW_Y    = 3'd1;
    localparam logic [2:0] REG_ROW_Z    = 3'd2;
    localparam logic [2:0] REG_FOCAL_X  = 3'd3;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd4;
    localparam logic [2:0] REG_CENTER_X = 3'd5;
    localparam logic [2:0] REG_CENTER_Y = 3'd6;

    typedef struct packed {
        logic [63:0] row_x;
        logic [63:0] row_y;
        logic [63:0] row_z;
        logic [15:0] focal_x;
        logic [15:0] focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
    } t_cfg;

    typedef struct packed {
        logic             ok;
        logic [REM_W-1:0] rem_c;
        logic [REM_W-1:0] rem_r;
        logic [DEN_W-1:0] den;
        logic [PIX_W-1:0] q_c;
        logic [PIX_W-1:0] q_r;
    } t_div;

endpackage

// ----- rtl/pcpp_front.sv -----
module pcpp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcpp_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [47:0]       i_point,
    output logic              o_valid,
    input  logic              i_ready,
    output pcpp_pkg::t_div    o_data
);
    import pcpp_pkg::*;

    logic [3:0] r_v;
    logic [3:0] rdy;

    logic signed [31:0] r_prod [3][3];
    logic signed [15:0] r_t [3];
    logic signed [COORD_W-1:0] r_c [3];
    logic signed [COORD_W-1:0] r_zc3;
    logic signed [50:0] r_m [4];
    t_div r_out;

    logic [63:0] rows [3];
    logic signed [15:0] pts [3];
    logic signed [NUM_W-1:0] nc, nr, lim;
    logic signed [COORD_W-1:0] zc;

    assign rows[0] = i_cfg.row_x;
    assign rows[1] = i_cfg.row_y;
    assign rows[2] = i_cfg.row_z;
    assign pts[0]  = i_point[15:0];
    assign pts[1]  = i_point[31:16];
    assign pts[2]  = i_point[47:32];

    assign rdy[3] = !r_v[3] || i_ready;
    assign rdy[2] = !r_v[2] || rdy[3];
    assign rdy[1] = !r_v[1] || rdy[2];
    assign rdy[0] = !r_v[0] || rdy[1];
    assign o_ready = rdy[0];
    assign o_valid = r_v[3];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
        end
    end

    // transform products
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= $signed(rows[i][16*j +: 16]) * pts[j];
                end
                r_t[i] <= $signed(rows[i][63:48]);
            end
        end
    end

    // camera coordinates in 1/16384 mm
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= COORD_W'(r_prod[i][0]) + COORD_W'(r_prod[i][1])
                        + COORD_W'(r_prod[i][2])
                        + {{(COORD_W-30){r_t[i][15]}}, r_t[i], 14'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_m[0] <= $signed({1'b0, i_cfg.focal_x})  * r_c[0];
            r_m[1] <= $signed({1'b0, i_cfg.center_x}) * r_c[2];
            r_m[2] <= $signed({1'b0, i_cfg.focal_y})  * r_c[1];
            r_m[3] <= $signed({1'b0, i_cfg.center_y}) * r_c[2];
            r_zc3  <= r_c[2];
        end
    end

    // numerators, range checks, divider setup
    always_comb begin
        zc  = r_zc3;
        nc  = NUM_W'(r_m[0]) + NUM_W'(r_m[1]);
        nr  = NUM_W'(r_m[2]) + NUM_W'(r_m[3]);
        lim = {{(NUM_W-COORD_W-16){zc[COORD_W-1]}}, zc, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_out.ok    <= (zc > 0) && (nc > 0) && (nr > 0) && (nc < lim) && (nr < lim);
            r_out.rem_c <= nc[REM_W-1:0];
            r_out.rem_r <= nr[REM_W-1:0];
            r_out.den   <= {zc[32:0], 15'b0};
            r_out.q_c   <= '0;
            r_out.q_r   <= '0;
        end
    end

endmodule

// ----- rtl/pcpp_div_cell.sv -----
module pcpp_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pcpp_pkg::t_div  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output pcpp_pkg::t_div  o_data
);
    import pcpp_pkg::*;

    logic r_v;
    t_div r_d;
    t_div n_d;
    logic ge_c, ge_r;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_data  = r_d;

    // one quotient bit per cell for both axes
    always_comb begin
        n_d   = i_data;
        ge_c  = i_data.rem_c >= REM_W'(i_data.den);
        ge_r  = i_data.rem_r >= REM_W'(i_data.den);
        if (ge_c) n_d.rem_c = i_data.rem_c - REM_W'(i_data.den);
        if (ge_r) n_d.rem_r = i_data.rem_r - REM_W'(i_data.den);
        n_d.q_c = {i_data.q_c[PIX_W-2:0], ge_c};
        n_d.q_r = {i_data.q_r[PIX_W-2:0], ge_r};
        n_d.den = i_data.den >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_d <= n_d;
    end

endmodule

// ----- rtl/point_cloud_pinhole_projector.sv -----
// each point passes 4 transform stages, 12 divider cells and an output register; the divider
// chain retires one quotient bit per cell
// throughput: one point per cycle; every stage stalls only if all stages after it are full
// points behind the camera or outside the image produce no item
// synchronous active-low reset clears valid flags and loads the identity transform
module point_cloud_pinhole_projector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // point_x, point_y, point_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // pixel_column, pixel_row
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import pcpp_pkg::*;

    t_cfg r_cfg;
    logic [NCELLS:0] v;
    logic [NCELLS:0] rdy;
    t_div d [NCELLS+1];
    logic r_ov;
    logic [PIX_W-1:0] r_col, r_row;
    logic out_rdy, hit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_x    <= 64'd16384;
            r_cfg.row_y    <= 64'd1073741824;
            r_cfg.row_z    <= 64'd70368744177664;
            r_cfg.focal_x  <= 16'd22176;
            r_cfg.focal_y  <= 16'd22104;
            r_cfg.center_x <= 16'd14980;
            r_cfg.center_y <= 16'd7913;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW_X:    r_cfg.row_x    <= i_cfg_data;
                REG_ROW_Y:    r_cfg.row_y    <= i_cfg_data;
                REG_ROW_Z:    r_cfg.row_z    <= i_cfg_data;
                REG_FOCAL_X:  r_cfg.focal_x  <= i_cfg_data[15:0];
                REG_FOCAL_Y:  r_cfg.focal_y  <= i_cfg_data[15:0];
                REG_CENTER_X: r_cfg.center_x <= i_cfg_data[15:0];
                REG_CENTER_Y: r_cfg.center_y <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    pcpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_point (i_s_axis_tdata),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_data  (d[0])
    );

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        pcpp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_data  (d[k]),
            .o_valid (v[k+1]),
            .i_ready (rdy[k+1]),
            .o_data  (d[k+1])
        );
    end

    assign out_rdy = !r_ov || i_m_axis_tready;
    assign rdy[NCELLS] = out_rdy;
    assign hit = d[NCELLS].ok
              && (d[NCELLS].q_c != '0) && ({1'b0, d[NCELLS].q_c} < (PIX_W+1)'(IMAGE_WIDTH))
              && (d[NCELLS].q_r != '0) && ({1'b0, d[NCELLS].q_r} < (PIX_W+1)'(IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_rdy) begin
            r_ov <= v[NCELLS] && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_col <= d[NCELLS].q_c;
            r_row <= d[NCELLS].q_r;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_row, r_col};

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_col != '0) && ({1'b0, r_col} < (PIX_W+1)'(IMAGE_WIDTH)))
        else $error("column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_row != '0) && ({1'b0, r_row} < (PIX_W+1)'(IMAGE_HEIGHT)))
        else $error("row out of range");
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule
